// File: rtl/nbl_pkg.sv
// ----------------------------------------------------------------------------
// nbl_pkg
// Shared types and constants for the nearest box locator.
// ----------------------------------------------------------------------------
`default_nettype none

package nbl_pkg;

   localparam int MAX_BOXES = 256;
   localparam int COORD_W   = 24;
   localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_W     = $clog2(MAX_BOXES + 1);
   localparam int OUT_IDX_W = 8;

   // distance = 128*max(gx,gy) + 53*min(gx,gy) + 128*gz
   localparam int GAP_W     = COORD_W;
   localparam int OCT_K     = 53;
   localparam int OCT_K_W   = 6;
   localparam int OCT_SHIFT = 7;
   localparam int PROD_W    = GAP_W + OCT_K_W;
   localparam int DIST_W    = GAP_W + OCT_SHIFT + 2;

   typedef enum logic {
      CMD_APPEND = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] hi_z;
      logic signed [COORD_W-1:0] hi_y;
      logic signed [COORD_W-1:0] hi_x;
      logic signed [COORD_W-1:0] lo_z;
      logic signed [COORD_W-1:0] lo_y;
      logic signed [COORD_W-1:0] lo_x;
   } box_type;

   localparam int BOX_W = $bits(box_type);

   // controller to datapath
   typedef struct packed {
      logic append;
      logic capture;
      logic issue;
      logic rsp_empty;
      logic rsp_query;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic last_rd;
      logic pipe_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: rtl/nbl_ram.sv
// ----------------------------------------------------------------------------
// nbl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/nbl_ctrl.sv
// ----------------------------------------------------------------------------
// nbl_ctrl
// Sequencer for append and query items: issues table reads during a scan
// and waits for the distance pipeline to drain before the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nbl_ctrl
   import nbl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire cmd_type     cmd,
   input  wire dp_stat_type stat,
   output logic             busy,
   output ctl_type          ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (cmd == CMD_QUERY)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.empty || stat.last_rd) begin
               state_in = stat.empty ? ST_IDLE : ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            ctl.append  = start && (cmd == CMD_APPEND);
            ctl.capture = start && (cmd == CMD_QUERY);
         end
         ST_SCAN: begin
            ctl.rsp_empty = stat.empty;
            ctl.issue     = !stat.empty;
         end
         ST_DRAIN: begin
            ctl.rsp_query = !stat.pipe_busy;
         end
         default: busy = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/nbl_dp.sv
// ----------------------------------------------------------------------------
// nbl_dp
// Box table, scan address, distance pipeline, best-box tracking and
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module nbl_dp
   import nbl_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ctl_type                       ctl,
   input  wire logic signed [COORD_W-1:0]     min_x,
   input  wire logic signed [COORD_W-1:0]     min_y,
   input  wire logic signed [COORD_W-1:0]     min_z,
   input  wire logic signed [COORD_W-1:0]     max_x,
   input  wire logic signed [COORD_W-1:0]     max_y,
   input  wire logic signed [COORD_W-1:0]     max_z,
   input  wire logic signed [COORD_W-1:0]     point_x,
   input  wire logic signed [COORD_W-1:0]     point_y,
   input  wire logic signed [COORD_W-1:0]     point_z,
   output dp_stat_type                        stat,
   output logic                               rsp_valid,
   output logic [OUT_IDX_W-1:0]               rsp_box_index,
   output logic                               rsp_inside_res,
   output logic [1:0]                         rsp_status
);

   function automatic logic [GAP_W-1:0] axis_gap(
      input logic signed [COORD_W-1:0] p,
      input logic signed [COORD_W-1:0] lo,
      input logic signed [COORD_W-1:0] hi
   );
      logic signed [COORD_W:0] below;
      logic signed [COORD_W:0] above;
      below = (COORD_W+1)'(lo) - (COORD_W+1)'(p);
      above = (COORD_W+1)'(p) - (COORD_W+1)'(hi);
      if (p < lo) begin
         return below[GAP_W-1:0];
      end else if (hi < p) begin
         return above[GAP_W-1:0];
      end
      return '0;
   endfunction

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          addr_ff, addr_in;
   logic                      full;
   logic signed [COORD_W-1:0] pt_x_ff, pt_y_ff, pt_z_ff;
   box_type                   wr_box;
   logic [BOX_W-1:0]          rd_word;
   box_type                   rd_box;

   // pipeline: ram read, gaps, octile parts, distance
   logic [3:0]                vld_ff, vld_in;
   logic [IDX_W-1:0]          idx0_ff, idx1_ff, idx2_ff, idx3_ff;
   logic [GAP_W-1:0]          gx_ff, gy_ff, gz1_ff;
   logic [GAP_W-1:0]          big_ff, gz2_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [DIST_W-1:0]         dist_ff;
   logic [GAP_W-1:0]          big_w, small_w;

   logic                      have_best_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [DIST_W-1:0]         best_d_ff;
   logic                      take;

   logic                      rsp_valid_ff;
   logic [OUT_IDX_W-1:0]      rsp_idx_ff;
   logic                      rsp_inside_ff;
   status_type                rsp_status_ff;

   assign full = (count_ff == CNT_W'(MAX_BOXES));

   // table
   assign wr_box = '{hi_z: max_z, hi_y: max_y, hi_x: max_x,
                     lo_z: min_z, lo_y: min_y, lo_x: min_x};

   nbl_ram #(
      .WIDTH (BOX_W),
      .DEPTH (MAX_BOXES)
   ) u_box_ram (
      .clock   (clock),
      .wr_en   (ctl.append && !full),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_box),
      .rd_en   (ctl.issue),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   assign rd_box = box_type'(rd_word);

   // count and scan address
   always_comb begin
      count_in = count_ff;
      if (ctl.append && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
      addr_in = addr_ff;
      if (ctl.capture) begin
         addr_in = '0;
      end else if (ctl.issue) begin
         addr_in = addr_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (ctl.capture) begin
         pt_x_ff <= point_x;
         pt_y_ff <= point_y;
         pt_z_ff <= point_z;
      end
   end

   assign stat.empty     = (count_ff == '0);
   assign stat.last_rd   = (CNT_W'(addr_ff) == (count_ff - CNT_W'(1)));
   assign stat.pipe_busy = |vld_ff;

   // distance pipeline
   assign vld_in = {vld_ff[2:0], ctl.issue};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign big_w   = (gx_ff > gy_ff) ? gx_ff : gy_ff;
   assign small_w = (gx_ff > gy_ff) ? gy_ff : gx_ff;

   always_ff @(posedge clock) begin
      idx0_ff <= addr_ff;
      gx_ff   <= axis_gap(pt_x_ff, rd_box.lo_x, rd_box.hi_x);
      gy_ff   <= axis_gap(pt_y_ff, rd_box.lo_y, rd_box.hi_y);
      gz1_ff  <= axis_gap(pt_z_ff, rd_box.lo_z, rd_box.hi_z);
      idx1_ff <= idx0_ff;
      big_ff  <= big_w;
      prod_ff <= PROD_W'(small_w) * PROD_W'(OCT_K);
      gz2_ff  <= gz1_ff;
      idx2_ff <= idx1_ff;
      dist_ff <= (DIST_W'(big_ff) << OCT_SHIFT) + DIST_W'(prod_ff)
                 + (DIST_W'(gz2_ff) << OCT_SHIFT);
      idx3_ff <= idx2_ff;
   end

   // best box, ties keep the earlier one
   assign take = vld_ff[3] && (!have_best_ff || (dist_ff < best_d_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
      end else if (ctl.capture) begin
         have_best_ff <= 1'b0;
      end else if (vld_ff[3]) begin
         have_best_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff <= idx3_ff;
         best_d_ff   <= dist_ff;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.append || ctl.rsp_empty || ctl.rsp_query;
      end
   end

   always_ff @(posedge clock) begin
      priority if (ctl.append) begin
         rsp_idx_ff    <= full ? '0 : OUT_IDX_W'(count_ff);
         rsp_inside_ff <= 1'b0;
         rsp_status_ff <= full ? STAT_FULL : STAT_OK;
      end else if (ctl.rsp_empty) begin
         rsp_idx_ff    <= '0;
         rsp_inside_ff <= 1'b0;
         rsp_status_ff <= STAT_EMPTY;
      end else if (ctl.rsp_query) begin
         rsp_idx_ff    <= OUT_IDX_W'(best_idx_ff);
         rsp_inside_ff <= (best_d_ff == '0);
         rsp_status_ff <= STAT_OK;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_box_index  = rsp_idx_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

// File: rtl/nearest_box_locator.sv
// ----------------------------------------------------------------------------
// nearest_box_locator
// An append item is taken at once and its result is strobed in the next
// cycle. A query item keeps busy high while the scan reads one stored box per
// cycle from the box table through a four-stage distance pipeline and
// while that pipeline drains; with an empty table it goes straight back
// to idle. The result is strobed in the cycle in which busy falls. Results
// are shown on rsp_valid for exactly one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_box_locator
   import nbl_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_cmd,
   input  wire logic signed [COORD_W-1:0] req_min_x,
   input  wire logic signed [COORD_W-1:0] req_min_y,
   input  wire logic signed [COORD_W-1:0] req_min_z,
   input  wire logic signed [COORD_W-1:0] req_max_x,
   input  wire logic signed [COORD_W-1:0] req_max_y,
   input  wire logic signed [COORD_W-1:0] req_max_z,
   input  wire logic signed [COORD_W-1:0] req_point_x,
   input  wire logic signed [COORD_W-1:0] req_point_y,
   input  wire logic signed [COORD_W-1:0] req_point_z,
   output logic                           rsp_valid,
   output logic [OUT_IDX_W-1:0]           rsp_box_index,
   output logic                           rsp_inside_res,
   output logic [1:0]                     rsp_status
);

   ctl_type     ctl;
   dp_stat_type stat;

   nbl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (cmd_type'(req_cmd)),
      .stat  (stat),
      .busy  (busy),
      .ctl   (ctl)
   );

   nbl_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .min_x          (req_min_x),
      .min_y          (req_min_y),
      .min_z          (req_min_z),
      .max_x          (req_max_x),
      .max_y          (req_max_y),
      .max_z          (req_max_z),
      .point_x        (req_point_x),
      .point_y        (req_point_y),
      .point_z        (req_point_z),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_box_index  (rsp_box_index),
      .rsp_inside_res (rsp_inside_res),
      .rsp_status     (rsp_status)
   );

   a_query_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("query finished without a result");

   a_append_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_APPEND)) |=> rsp_valid)
      else $error("append item without a result");

   a_inside_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inside_res) |-> (rsp_status == STAT_OK))
      else $error("inside flag with a failure status");

endmodule

`default_nettype wire
